// ===== src/phkm_pkg.sv =====
`default_nettype none

package phkm_pkg;

   // Word buffer capacity and hash slot count.
   localparam int MAX_LEN        = 17;
   localparam int NUM_SLOTS      = 30;
   localparam int TABLE_SLOTS    = 30;
   localparam int MIN_LEN        = 4;
   localparam int THIRD_KEY_POS  = 8;
   localparam int MAX_WEIGHT     = 30;
   localparam int KW_MAX_LEN     = 17;

   // Derived widths. The length counter saturates at MAX_LEN + 1.
   localparam int LEN_W   = $clog2(MAX_LEN + 2);
   localparam int WSUM_W  = $clog2(3 * MAX_WEIGHT + 1);
   localparam int HASH_W  = $clog2(MAX_LEN + 2 + 3 * MAX_WEIGHT);
   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int KW_LEN_W = $clog2(KW_MAX_LEN + 1);
   localparam int ID_W    = 5;
   localparam int OUT_SLOT_W = 5;

   // One input item: a character and the end-of-word flag.
   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } phkm_req_type;

   // One result item.
   typedef struct packed {
      logic                  found;
      logic [ID_W-1:0]       member_id;
      logic [OUT_SLOT_W-1:0] slot_index;
   } phkm_rsp_type;

   // Status handed from the scanner to the lookup stage for a finished word.
   typedef struct packed {
      logic [LEN_W-1:0]       len;
      logic [HASH_W-1:0]      hash;
      logic [TABLE_SLOTS-1:0] match;
   } phkm_scan_type;

   // One slot of the keyword table; the name is right-aligned, first
   // character in the highest used byte.
   typedef struct packed {
      logic [8*KW_MAX_LEN-1:0] name;
      logic [KW_LEN_W-1:0]     len;
      logic [ID_W-1:0]         id;
   } phkm_kw_type;

   localparam phkm_kw_type KW_TABLE [TABLE_SLOTS] = '{
      '{'0, 5'd0, 5'd0},
      '{'0, 5'd0, 5'd0},
      '{'0, 5'd0, 5'd0},
      '{'0, 5'd0, 5'd0},
      '{"text", 5'd4, 5'd12},
      '{'0, 5'd0, 5'd0},
      '{"border", 5'd6, 5'd4},
      '{"hscroll", 5'd7, 5'd6},
      '{"maxChars", 5'd8, 5'd8},
      '{"textWidth", 5'd9, 5'd15},
      '{"textHeight", 5'd10, 5'd14},
      '{"length", 5'd6, 5'd7},
      '{"_height", 5'd7, 5'd19},
      '{"variable", 5'd8, 5'd17},
      '{"maxscroll", 5'd9, 5'd9},
      '{"background", 5'd10, 5'd2},
      '{"borderColor", 5'd11, 5'd5},
      '{"mouseWheelEnabled", 5'd17, 5'd21},
      '{"autoSize", 5'd8, 5'd1},
      '{"multiline", 5'd9, 5'd10},
      '{"backgroundColor", 5'd15, 5'd3},
      '{"scroll", 5'd6, 5'd11},
      '{'0, 5'd0, 5'd0},
      '{"wordWrap", 5'd8, 5'd18},
      '{"textColor", 5'd9, 5'd13},
      '{'0, 5'd0, 5'd0},
      '{"_width", 5'd6, 5'd20},
      '{'0, 5'd0, 5'd0},
      '{'0, 5'd0, 5'd0},
      '{"type", 5'd4, 5'd16}
   };

   // Hash weight of one character.
   function automatic logic [WSUM_W-1:0] char_weight(input logic [7:0] c);
      logic [WSUM_W-1:0] w;
      case (c)
         "a", "b", "e", "h", "m", "o", "s", "t": w = WSUM_W'(0);
         "_", "l", "n", "v":                     w = WSUM_W'(5);
         "u":                                    w = WSUM_W'(10);
         "c", "r", "w":                          w = WSUM_W'(15);
         "y":                                    w = WSUM_W'(25);
         default:                                w = WSUM_W'(MAX_WEIGHT);
      endcase
      return w;
   endfunction

   // Character of a slot's keyword at a position; zero past its end.
   function automatic logic [7:0] kw_char(input int slot, input logic [LEN_W-1:0] pos);
      int lsb;
      logic [7:0] c;
      c = 8'h00;
      if (int'(pos) < int'(KW_TABLE[slot].len)) begin
         lsb = 8 * (int'(KW_TABLE[slot].len) - 1 - int'(pos));
         c = KW_TABLE[slot].name[lsb +: 8];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/phkm_scan.sv =====
`default_nettype none

module phkm_scan
   import phkm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_valid,
   input  wire phkm_req_type  step_item,
   output phkm_scan_type      scan
);

   logic [LEN_W-1:0]       len_ff, len_in;
   logic [WSUM_W-1:0]      wsum_ff, wsum_in;
   logic [TABLE_SLOTS-1:0] match_ff, match_in;
   logic [LEN_W-1:0]       len_next;
   logic [WSUM_W-1:0]      wsum_next;
   logic [TABLE_SLOTS-1:0] match_next;
   logic                   key_pos;

   // Per-character update of the length, the weight sum and the per-slot
   // running match against every table keyword.
   always_comb begin
      key_pos = (len_ff == LEN_W'(0)) || (len_ff == LEN_W'(1))
                || (len_ff == LEN_W'(THIRD_KEY_POS));
      len_next = (int'(len_ff) <= MAX_LEN) ? len_ff + LEN_W'(1) : len_ff;
      wsum_next = key_pos ? wsum_ff + char_weight(step_item.char_in) : wsum_ff;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (int'(len_ff) < MAX_LEN) begin
            match_next[s] = ((len_ff == LEN_W'(0)) || match_ff[s])
                            && (kw_char(s, len_ff) == step_item.char_in);
         end else begin
            match_next[s] = match_ff[s];
         end
      end
   end

   // A finished word clears the counters for the next one.
   always_comb begin
      len_in   = len_ff;
      wsum_in  = wsum_ff;
      match_in = match_ff;
      if (step_valid) begin
         len_in   = step_item.last_char ? '0 : len_next;
         wsum_in  = step_item.last_char ? '0 : wsum_next;
         match_in = match_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         wsum_ff <= '0;
      end else begin
         len_ff  <= len_in;
         wsum_ff <= wsum_in;
      end
      match_ff <= match_in;
   end

   // Word status as it stands with the current character included.
   assign scan.len   = len_next;
   assign scan.hash  = HASH_W'(len_next) + HASH_W'(wsum_next);
   assign scan.match = match_next;

endmodule

`default_nettype wire

// ===== src/phkm_lookup.sv =====
`default_nettype none

module phkm_lookup
   import phkm_pkg::*;
(
   input  phkm_scan_type scan,
   output phkm_rsp_type  rsp
);

   logic              len_ok;
   logic              hash_ok;
   logic [SLOT_W-1:0] sel;
   phkm_kw_type       entry;
   logic              hit;

   // Range checks, then the slot's keyword must be present, match every
   // character and have the same length.
   always_comb begin
      len_ok  = (int'(scan.len) >= MIN_LEN) && (int'(scan.len) <= MAX_LEN);
      hash_ok = (int'(scan.hash) <= NUM_SLOTS - 1) && (int'(scan.hash) < TABLE_SLOTS);
      sel     = hash_ok ? scan.hash[SLOT_W-1:0] : '0;
      entry   = KW_TABLE[sel];
      hit     = len_ok && hash_ok && (entry.id != ID_W'(0)) && scan.match[sel]
                && (int'(entry.len) == int'(scan.len));
      rsp.found      = hit;
      rsp.member_id  = hit ? entry.id : '0;
      rsp.slot_index = hit ? OUT_SLOT_W'(sel) : '0;
   end

endmodule

`default_nettype wire

// ===== src/perfect_hash_keyword_matcher_core.sv =====
`default_nettype none

// Keyword matcher over a character stream. One character enters per item,
// and the item carrying last_char gives one result (found, member id, hash
// slot); other items give none. Every character is compared on arrival
// against all table keywords in parallel, so the final lookup is a table
// read and one select. The block takes one item per cycle: an input register
// feeds the scanner and a result register holds the answer, so the result of
// a word is loaded into the result register as its last character leaves
// the input register. Input stalls only when a result waits in the output
// register and the next word also ends before it is taken.
module perfect_hash_keyword_matcher_core
   import phkm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire phkm_req_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output phkm_rsp_type       rsp_data
);

   logic          s1_valid_ff, s1_valid_in;
   phkm_req_type  s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   phkm_rsp_type  rsp_ff, rsp_in;
   logic          out_free;
   logic          s1_fire;
   phkm_scan_type scan;
   phkm_rsp_type  lookup_rsp;

   // Handshake: the input stage moves on unless it holds a last character
   // and the result register is still occupied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_item_ff.last_char || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   phkm_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (s1_fire),
      .step_item  (s1_item_ff),
      .scan       (scan)
   );

   phkm_lookup u_lookup (
      .scan (scan),
      .rsp  (lookup_rsp)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_fire && s1_item_ff.last_char) begin
         rsp_valid_in = 1'b1;
         rsp_in       = lookup_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A match always names a real keyword.
   a_found_has_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.member_id != '0)
      else $error("found result without member id");

   // A rejection carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |->
         rsp_ff.member_id == '0 && rsp_ff.slot_index == '0)
      else $error("rejected word with nonzero fields");

   // A match lies inside the slot range.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> int'(rsp_ff.slot_index) < NUM_SLOTS)
      else $error("slot index out of range");

   // A new result appears only after a last character left the input stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && s1_item_ff.last_char))
      else $error("result without a finished word");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_perfect_hash_keyword_matcher_core.sv =====
`default_nettype none

module tb_perfect_hash_keyword_matcher_core
   import phkm_pkg::*;
();

   typedef bit [7:0] char_q_type [$];

   // Matcher geometry as the table below assumes it.
   localparam int WORD_CAP    = 17;
   localparam int SLOT_COUNT  = 30;
   localparam int MIN_WORD    = 4;
   localparam int KEY3_POS    = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   // Keyword table, indexed by hash slot; an empty name marks an empty slot.
   string kw_name [SLOT_COUNT] = '{
      "", "", "", "", "text", "", "border", "hscroll", "maxChars", "textWidth",
      "textHeight", "length", "_height", "variable", "maxscroll", "background",
      "borderColor", "mouseWheelEnabled", "autoSize", "multiline",
      "backgroundColor", "scroll", "", "wordWrap", "textColor", "", "_width",
      "", "", "type"
   };
   int kw_id [SLOT_COUNT] = '{
      0, 0, 0, 0, 12, 0, 4, 6, 8, 15, 14, 7, 19, 17, 9, 2, 5, 21, 1, 10,
      3, 11, 0, 18, 13, 0, 20, 0, 0, 16
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   phkm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   phkm_rsp_type rsp_data;

   phkm_req_type pending_chars [$];
   phkm_rsp_type expected_results [$];
   phkm_rsp_type want;

   // Predicted matcher state.
   bit [7:0] word_chars [WORD_CAP];
   int       word_len = 0;

   int  char_total = 0;
   int  word_total = 0;
   int  chars_accepted = 0;
   int  results_checked = 0;
   int  matches_seen = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  quiet;

   perfect_hash_keyword_matcher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A stretch of the run in which neither side idles.
   assign quiet = (chars_accepted >= 500) && (chars_accepted < 700);

   function automatic int char_hash_weight(input bit [7:0] c);
      case (c)
         "a", "b", "e", "h", "m", "o", "s", "t": return 0;
         "_", "l", "n", "v":                     return 5;
         "u":                                    return 10;
         "c", "r", "w":                          return 15;
         "y":                                    return 25;
         default:                                return 30;
      endcase
   endfunction

   // Advance the predicted state by one character; a last character yields
   // exactly one expected result.
   task automatic take_char(input phkm_req_type it);
      int len;
      int hash;
      int i;
      bit hit;
      phkm_rsp_type res;
      if (word_len < WORD_CAP) word_chars[word_len] = it.char_in;
      if (word_len <= WORD_CAP) word_len++;
      if (it.last_char) begin
         len = word_len;
         word_len = 0;
         res = '0;
         if (len >= MIN_WORD && len <= WORD_CAP) begin
            hash = len + char_hash_weight(word_chars[0]) + char_hash_weight(word_chars[1]);
            if (len > KEY3_POS) hash += char_hash_weight(word_chars[KEY3_POS]);
            if (hash < SLOT_COUNT && kw_id[hash] != 0 && kw_name[hash].len() == len) begin
               hit = 1'b1;
               for (i = 0; i < len; i++) begin
                  if (kw_name[hash][i] != word_chars[i]) hit = 1'b0;
               end
               if (hit) begin
                  res.found = 1'b1;
                  res.member_id = ID_W'(kw_id[hash]);
                  res.slot_index = OUT_SLOT_W'(hash);
               end
            end
         end
         expected_results.push_back(res);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // Queue one word as items, flagging its final character.
   task automatic queue_word(input char_q_type w);
      phkm_req_type it;
      int i;
      for (i = 0; i < w.size(); i++) begin
         it.char_in = w[i];
         it.last_char = (i == w.size() - 1);
         pending_chars.push_back(it);
      end
      char_total += w.size();
      word_total++;
   endtask

   function automatic char_q_type text_chars(input string s);
      char_q_type q;
      int i;
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // Letters drawn from every weight class, plus a few that weigh the most.
   function automatic char_q_type random_letters(input int n);
      string abc;
      char_q_type q;
      int i;
      abc = "abehmostlnvu_crwyxdgkCHWS";
      for (i = 0; i < n; i++) q.push_back(abc[$urandom_range(abc.len() - 1)]);
      return q;
   endfunction

   function automatic int random_keyword_slot();
      int s;
      s = $urandom_range(SLOT_COUNT - 1);
      while (kw_id[s] == 0) s = $urandom_range(SLOT_COUNT - 1);
      return s;
   endfunction

   // Driver: offers the next pending item, holding it until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_chars.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
            req_data <= pending_chars.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started once a few hundred items have gone in.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && chars_accepted >= 250) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: predicts from accepted items, then checks accepted results.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         take_char(req_data);
         chars_accepted <= chars_accepted + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, expected %b", rsp_data.found, want.found));
            if (rsp_data.member_id !== want.member_id)
               report_mismatch($sformatf("member_id %0d, expected %0d",
                  rsp_data.member_id, want.member_id));
            if (rsp_data.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, expected %0d",
                  rsp_data.slot_index, want.slot_index));
            if (want.found) matches_seen <= matches_seen + 1;
         end
         results_checked <= results_checked + 1;
      end
      rsp_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 6);
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out with %0d results still expected.", expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      char_q_type w;
      char_q_type letter;
      int pick;
      int s;
      int pos;
      int n;
      int i;

      // Directed words: the named keywords, a near miss and rejections.
      queue_word(text_chars("text"));
      queue_word(text_chars("type"));
      queue_word(text_chars("mouseWheelEnabled"));
      queue_word(text_chars("backgroundColor"));
      queue_word(text_chars("taxt"));                 // lands on a keyword slot, differs
      queue_word(text_chars("ab"));                   // too short
      w = '{8'hFF};
      queue_word(w);                                  // one top-valued character
      queue_word(text_chars("mouseWheelEnabledXYZ")); // too long
      queue_word(text_chars("aaaaa"));                // empty slot
      queue_word(text_chars("Text"));                 // hash above the table
      queue_word(text_chars("textColoX"));            // ninth character adds weight

      // Random words, mostly keywords and close relatives of them.
      while (pending_chars.size() < 1000) begin
         pick = $urandom_range(99);
         s = random_keyword_slot();
         w = text_chars(kw_name[s]);
         if (pick < 45) begin
            queue_word(w);
         end else if (pick < 65) begin
            pos = $urandom_range(w.size() - 1);
            if ($urandom_range(1)) begin
               w[pos] = 8'($urandom_range(1, 255));
            end else begin
               letter = random_letters(1);
               w[pos] = letter[0];
            end
            queue_word(w);
         end else if (pick < 75) begin
            if ($urandom_range(1)) begin
               n = $urandom_range(1, 2);
               for (i = 0; i < n; i++) void'(w.pop_back());
            end else begin
               w = {w, random_letters($urandom_range(1, 2))};
            end
            queue_word(w);
         end else if (pick < 90) begin
            queue_word(random_letters($urandom_range(1, 20)));
         end else begin
            n = $urandom_range(1, 22);
            w = {};
            for (i = 0; i < n; i++) w.push_back(8'($urandom_range(1, 255)));
            queue_word(w);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to go in and every result to come out.
      do @(negedge clock); while (chars_accepted != char_total);
      do @(negedge clock); while (expected_results.size() != 0);
      repeat (10) @(negedge clock);

      $display("Sent %0d words in %0d characters, with a %0d-cycle result hold-off.",
         word_total, char_total, HOLD_CYCLES);
      $display("Checked %0d results, %0d of them keyword matches.",
         results_checked, matches_seen);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/phkm_pkg.sv
src/phkm_scan.sv
src/phkm_lookup.sv
src/perfect_hash_keyword_matcher_core.sv
verif/tb_perfect_hash_keyword_matcher_core.sv
